// ===== sv/cnmt_pkg.sv =====
`timescale 1ns / 1ps
package cnmt_pkg;

    // Command codes
    localparam logic [1:0] CMD_ENROLL = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Status codes
    localparam logic [2:0] STS_ENROLLED   = 3'd0;
    localparam logic [2:0] STS_RECOGNISED = 3'd1;
    localparam logic [2:0] STS_STRANGER   = 3'd2;
    localparam logic [2:0] STS_REMOVED    = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND  = 3'd4;
    localparam logic [2:0] STS_FULL       = 3'd5;

    // Wide multiplier geometry: 4 x 2 chunks of 32 bits
    localparam int MUL_XW = 128;
    localparam int MUL_YW = 64;
    localparam int MUL_PW = 192;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ENR,
        ST_ENT,
        ST_LEN,
        ST_RD,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_CHK,
        ST_MUL
    } t_state;

    typedef enum logic [3:0] {
        OP_D2,
        OP_NN,
        OP_T2,
        OP_R,
        OP_MINE,
        OP_THEIRS,
        OP_CNN,
        OP_TT,
        OP_CMP
    } t_op;

    typedef struct packed {
        logic                start;
        logic [MUL_XW-1:0]   x;
        logic [MUL_YW-1:0]   y;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic [MUL_PW-1:0]   p;
    } t_mul_rsp;

endpackage

// ===== sv/cnmt_ram.sv =====
`timescale 1ns / 1ps
module cnmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cnmt_mul.sv =====
`timescale 1ns / 1ps
module cnmt_mul
    import cnmt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [MUL_XW-1:0] r_x;
    logic [MUL_YW-1:0] r_y;
    logic [MUL_PW-1:0] r_acc;
    logic [63:0]       r_pp;
    logic [2:0]        r_sh;
    logic              r_ppv;
    logic [3:0]        r_cnt;
    logic              r_done;

    logic [1:0]  xi;
    logic        yj;
    logic [31:0] x_chunk;
    logic [31:0] y_chunk;

    // Chunk select for the partial product being issued
    assign xi      = r_cnt[2:1];
    assign yj      = r_cnt[0];
    assign x_chunk = r_x[{xi, 5'b0} +: 32];
    assign y_chunk = r_y[{yj, 5'b0} +: 32];

    // Control: 8 partial products issued, each added in the cycle after its issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 4'd8;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_ppv && (r_cnt == 4'd8);
            if (i_req.start) begin
                r_cnt <= 4'd0;
                r_ppv <= 1'b0;
            end else if (r_cnt != 4'd8) begin
                r_cnt <= r_cnt + 4'd1;
                r_ppv <= 1'b1;
            end else begin
                r_ppv <= 1'b0;
            end
        end
    end

    // Datapath: registered 32x32 product, then shifted accumulate
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.x;
            r_y   <= i_req.y;
            r_acc <= '0;
        end else begin
            if (r_cnt != 4'd8) begin
                r_pp <= x_chunk * y_chunk;
                r_sh <= {1'b0, xi} + {2'b0, yj};
            end
            if (r_ppv) begin
                r_acc <= r_acc + (MUL_PW'(r_pp) << {r_sh, 5'b0});
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

`ifndef SYNTHESIS
    a_done_follows_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_ppv))
        else $error("multiplier done without a final add");
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ppv |-> (r_sh <= 3'd4))
        else $error("partial product shift out of range");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'd8)
        else $error("issue counter out of range");
`endif

endmodule

// ===== sv/cosine_nearest_match_table_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_cmd, i_value, i_last, i_slot
// result    out        o_valid / i_ready    o_status, o_match_slot, o_confidence
// config    in         i_cfg_we             i_cfg_data (match threshold)
//
// A remove is decided on acceptance; an enroll element passes through ST_ENR,
// after a lowest-free-slot scan on its first element; a query element is
// written on acceptance. A query's last element searches each valid entry of
// equal length: an element MAC, then up to 6 wide products on the shared 32x32
// multiplier; 33 more give the confidence. Reset (synchronous, active low)
// clears control state, valid marks and counters and presets the threshold.
// o_ready is low while a transaction is in progress or a result waits.
module cosine_nearest_match_table_top
    import cnmt_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int DIM     = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic signed [15:0] i_value,
    input  logic        i_last,
    input  logic [5:0]  i_slot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_match_slot,
    output logic [15:0] o_confidence,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW  = $clog2(DIM + 1);
    localparam int QAW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int VAW = (ENTRIES * DIM > 1) ? $clog2(ENTRIES * DIM) : 1;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [15:0]  r_thr;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_k, n_k;
    logic [SW:0]  r_tgt, n_tgt;
    logic [SW:0]  r_i, n_i;
    logic [15:0]  r_val, n_val;
    logic         r_last, n_last;
    logic [63:0]  r_dot, n_dot;
    logic [63:0]  r_na, n_na;
    logic [63:0]  r_nb, n_nb;
    logic [127:0] r_d2, n_d2;
    logic [127:0] r_nn, n_nn;
    logic [63:0]  r_t, n_t;
    logic [MUL_PW-1:0] r_mine, n_mine;
    logic         r_found, n_found;
    logic [SW-1:0] r_best, n_best;
    logic [127:0] r_bd2, n_bd2;
    logic [63:0]  r_bna, n_bna;
    logic [63:0]  r_bnb, n_bnb;
    logic [15:0]  r_c, n_c;
    logic [3:0]   r_bit, n_bit;
    logic         r_mstart, n_mstart;
    logic         r_ov, n_ov;
    logic [2:0]   r_status, n_status;
    logic [5:0]   r_mslot, n_mslot;
    logic [15:0]  r_conf, n_conf;

    // Memory ports
    logic           vec_we;
    logic [VAW-1:0] vec_waddr, vec_raddr;
    logic [15:0]    vec_rdata;
    logic           q_we;
    logic [15:0]    q_rdata;
    logic           len_we;
    logic [LW-1:0]  len_rdata;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    // Helpers
    logic              accept;
    logic [LW-1:0]     cnt_inc;
    logic [SW+5:0]     slot_w;
    logic [SW-1:0]     slot_idx;
    logic              slot_ok;
    logic              usable;
    logic signed [15:0] ma, mb;
    logic signed [31:0] prod;
    logic [63:0]       prod_ext;
    logic [15:0]       tval;
    logic [MUL_PW-1:0] d2_shift;
    logic [SW+5:0]     best_w, tgt_w;

    assign accept   = i_valid && o_ready;
    assign cnt_inc  = (r_cnt < LW'(DIM)) ? r_cnt + LW'(1) : r_cnt;
    assign slot_w   = {{SW{1'b0}}, i_slot};
    assign slot_idx = slot_w[SW-1:0];
    assign slot_ok  = (slot_w < (SW + 6)'(ENTRIES)) && r_valid[slot_idx];
    assign usable   = (r_tgt < (SW + 1)'(ENTRIES)) && !r_valid[r_tgt[SW-1:0]];
    assign tval     = r_c | (16'd1 << r_bit);
    assign d2_shift = {32'b0, r_d2, 32'b0};
    assign best_w   = {6'b0, r_best};
    assign tgt_w    = {5'b0, r_tgt};

    // Element multiplier, one product per cycle over M0..M2
    always_comb begin
        ma = (r_state == ST_M2) ? $signed(q_rdata) : $signed(vec_rdata);
        mb = (r_state == ST_M1) ? $signed(vec_rdata) : $signed(q_rdata);
    end
    assign prod     = ma * mb;
    assign prod_ext = {{32{prod[31]}}, prod};

    // Wide multiplier operands by operation
    always_comb begin
        mul_req.start = r_mstart;
        unique case (r_op)
            OP_D2:     begin mul_req.x = 128'(r_dot); mul_req.y = r_dot; end
            OP_NN:     begin mul_req.x = 128'(r_na);  mul_req.y = r_nb;  end
            OP_T2:     begin mul_req.x = 128'(r_thr); mul_req.y = 64'(r_thr); end
            OP_R:      begin mul_req.x = r_nn;        mul_req.y = r_t;   end
            OP_MINE:   begin mul_req.x = r_d2;        mul_req.y = r_bna; end
            OP_THEIRS: begin mul_req.x = r_bd2;       mul_req.y = r_na;  end
            OP_CNN:    begin mul_req.x = 128'(r_bna); mul_req.y = r_bnb; end
            OP_TT:     begin mul_req.x = 128'(tval);  mul_req.y = 64'(tval); end
            OP_CMP:    begin mul_req.x = r_nn;        mul_req.y = r_t;   end
            default:   begin mul_req.x = '0;          mul_req.y = '0;    end
        endcase
    end

    cnmt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Memory addressing
    assign vec_we    = (r_state == ST_ENR) && usable && (r_pos < LW'(DIM));
    assign vec_waddr = VAW'(r_tgt) * VAW'(DIM) + VAW'(r_pos);
    assign vec_raddr = VAW'(r_i) * VAW'(DIM) + VAW'(r_k);
    assign q_we      = accept && (i_cmd == CMD_QUERY) && (r_cnt < LW'(DIM));
    assign len_we    = (r_state == ST_ENR) && r_last && usable;

    cnmt_ram #(.WIDTH(16), .DEPTH(ENTRIES * DIM)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (r_val),
        .i_raddr (vec_raddr),
        .o_rdata (vec_rdata)
    );

    cnmt_ram #(.WIDTH(16), .DEPTH(DIM)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_cnt[QAW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_k[QAW-1:0]),
        .o_rdata (q_rdata)
    );

    cnmt_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_tgt[SW-1:0]),
        .i_wdata (r_len),
        .i_raddr (r_i[SW-1:0]),
        .o_rdata (len_rdata)
    );

    assign o_ready = (r_state == ST_IDLE) && !r_ov;

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_valid  = r_valid;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_pos    = r_pos;
        n_k      = r_k;
        n_tgt    = r_tgt;
        n_i      = r_i;
        n_val    = r_val;
        n_last   = r_last;
        n_dot    = r_dot;
        n_na     = r_na;
        n_nb     = r_nb;
        n_d2     = r_d2;
        n_nn     = r_nn;
        n_t      = r_t;
        n_mine   = r_mine;
        n_found  = r_found;
        n_best   = r_best;
        n_bd2    = r_bd2;
        n_bna    = r_bna;
        n_bnb    = r_bnb;
        n_c      = r_c;
        n_bit    = r_bit;
        n_mstart = 1'b0;
        n_ov     = r_ov && !i_ready;
        n_status = r_status;
        n_mslot  = r_mslot;
        n_conf   = r_conf;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_cmd == CMD_REMOVE) begin
                        n_ov   = 1'b1;
                        n_conf = '0;
                        if (slot_ok) begin
                            n_valid[slot_idx] = 1'b0;
                            n_status = STS_REMOVED;
                            n_mslot  = i_slot;
                        end else begin
                            n_status = STS_NOT_FOUND;
                            n_mslot  = '0;
                        end
                    end else if (i_cmd == CMD_ENROLL) begin
                        n_val  = i_value;
                        n_last = i_last;
                        n_pos  = r_cnt;
                        n_cnt  = i_last ? '0 : cnt_inc;
                        n_len  = cnt_inc;
                        n_i    = '0;
                        n_state = (r_cnt == '0) ? ST_SCAN : ST_ENR;
                    end else if (i_cmd == CMD_QUERY) begin
                        n_cnt = i_last ? '0 : cnt_inc;
                        if (i_last) begin
                            n_len   = cnt_inc;
                            n_i     = '0;
                            n_found = 1'b0;
                            n_state = ST_ENT;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            // Lowest free slot, one valid mark a cycle
            ST_SCAN: begin
                if (!r_valid[r_i[SW-1:0]]) begin
                    n_tgt   = r_i;
                    n_state = ST_ENR;
                end else if (r_i == (SW + 1)'(ENTRIES - 1)) begin
                    n_tgt   = (SW + 1)'(ENTRIES);
                    n_state = ST_ENR;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            ST_ENR: begin
                n_state = ST_IDLE;
                if (r_last) begin
                    n_ov   = 1'b1;
                    n_conf = '0;
                    if (usable) begin
                        n_valid[r_tgt[SW-1:0]] = 1'b1;
                        n_status = STS_ENROLLED;
                        n_mslot  = tgt_w[5:0];
                    end else begin
                        n_status = STS_FULL;
                        n_mslot  = '0;
                    end
                end
            end

            // Next candidate entry, or the confidence phase
            ST_ENT: begin
                if (r_i == (SW + 1)'(ENTRIES)) begin
                    if (r_found) begin
                        n_op     = OP_CNN;
                        n_mstart = 1'b1;
                        n_state  = ST_MUL;
                    end else begin
                        n_ov     = 1'b1;
                        n_status = STS_STRANGER;
                        n_mslot  = '0;
                        n_conf   = '0;
                        n_state  = ST_IDLE;
                    end
                end else if (!r_valid[r_i[SW-1:0]]) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_state = ST_LEN;
                end
            end

            ST_LEN: begin
                if (len_rdata == r_len) begin
                    n_dot   = '0;
                    n_na    = '0;
                    n_nb    = '0;
                    n_k     = '0;
                    n_state = ST_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_ENT;
                end
            end

            ST_RD: n_state = ST_M0;

            // Element MAC: dot, entry norm, query norm
            ST_M0: begin
                n_dot   = r_dot + prod_ext;
                n_state = ST_M1;
            end
            ST_M1: begin
                n_na    = r_na + prod_ext;
                n_state = ST_M2;
            end
            ST_M2: begin
                n_nb = r_nb + prod_ext;
                if (r_k + LW'(1) == r_len) begin
                    n_state = ST_CHK;
                end else begin
                    n_k     = r_k + LW'(1);
                    n_state = ST_RD;
                end
            end

            ST_CHK: begin
                if ($signed(r_dot) <= 64'sd0) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_ENT;
                end else begin
                    n_op     = OP_D2;
                    n_mstart = 1'b1;
                    n_state  = ST_MUL;
                end
            end

            // Wide products through the shared multiplier
            ST_MUL: begin
                if (mul_rsp.done) begin
                    n_mstart = 1'b1;
                    unique case (r_op)
                        OP_D2: begin
                            n_d2 = mul_rsp.p[127:0];
                            n_op = OP_NN;
                        end
                        OP_NN: begin
                            n_nn = mul_rsp.p[127:0];
                            n_op = OP_T2;
                        end
                        OP_T2: begin
                            n_t  = mul_rsp.p[63:0];
                            n_op = OP_R;
                        end
                        OP_R: begin
                            if (d2_shift > mul_rsp.p && r_found) begin
                                n_op = OP_MINE;
                            end else begin
                                n_mstart = 1'b0;
                                n_i      = r_i + 1'b1;
                                n_state  = ST_ENT;
                                if (d2_shift > mul_rsp.p) begin
                                    n_found = 1'b1;
                                    n_best  = r_i[SW-1:0];
                                    n_bd2   = r_d2;
                                    n_bna   = r_na;
                                    n_bnb   = r_nb;
                                end
                            end
                        end
                        OP_MINE: begin
                            n_mine = mul_rsp.p;
                            n_op   = OP_THEIRS;
                        end
                        OP_THEIRS: begin
                            n_mstart = 1'b0;
                            n_i      = r_i + 1'b1;
                            n_state  = ST_ENT;
                            if (r_mine > mul_rsp.p) begin
                                n_best = r_i[SW-1:0];
                                n_bd2  = r_d2;
                                n_bna  = r_na;
                                n_bnb  = r_nb;
                            end
                        end
                        OP_CNN: begin
                            n_nn  = mul_rsp.p[127:0];
                            n_c   = '0;
                            n_bit = 4'd15;
                            n_op  = OP_TT;
                        end
                        OP_TT: begin
                            n_t  = mul_rsp.p[63:0];
                            n_op = OP_CMP;
                        end
                        OP_CMP: begin
                            n_c = (mul_rsp.p <= {32'b0, r_bd2, 32'b0}) ? tval : r_c;
                            if (r_bit == 4'd0) begin
                                n_mstart = 1'b0;
                                n_ov     = 1'b1;
                                n_status = STS_RECOGNISED;
                                n_mslot  = best_w[5:0];
                                n_conf   = n_c;
                                n_state  = ST_IDLE;
                            end else begin
                                n_bit = r_bit - 4'd1;
                                n_op  = OP_TT;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_D2;
            r_valid  <= '0;
            r_cnt    <= '0;
            r_tgt    <= '0;
            r_thr    <= 16'd39322;
            r_mstart <= 1'b0;
            r_ov     <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_valid  <= n_valid;
            r_cnt    <= n_cnt;
            r_tgt    <= n_tgt;
            r_mstart <= n_mstart;
            r_ov     <= n_ov;
            r_found  <= n_found;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_i      <= n_i;
        r_val    <= n_val;
        r_last   <= n_last;
        r_dot    <= n_dot;
        r_na     <= n_na;
        r_nb     <= n_nb;
        r_d2     <= n_d2;
        r_nn     <= n_nn;
        r_t      <= n_t;
        r_mine   <= n_mine;
        r_best   <= n_best;
        r_bd2    <= n_bd2;
        r_bna    <= n_bna;
        r_bnb    <= n_bnb;
        r_c      <= n_c;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_mslot  <= n_mslot;
        r_conf   <= n_conf;
    end

    assign o_valid      = r_ov;
    assign o_status     = r_status;
    assign o_match_slot = r_mslot;
    assign o_confidence = r_conf;

`ifndef SYNTHESIS
    a_conf_only_recognised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_status != STS_RECOGNISED) |-> (r_conf == 16'd0))
        else $error("confidence set on a result other than recognised");
    a_slot_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_status == STS_STRANGER || r_status == STS_NOT_FOUND ||
                  r_status == STS_FULL)) |-> (r_mslot == 6'd0))
        else $error("slot reported on a miss");
    a_tiebreak_needs_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && (r_op == OP_MINE || r_op == OP_THEIRS)) |-> r_found)
        else $error("winner comparison without a current best");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LW'(DIM))
        else $error("element count beyond DIM");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import cnmt_pkg::*;

    localparam int         N_ENT      = 64;
    localparam int         N_DIM      = 128;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         ITEMS_PER_PHASE = 475;

    // Expected result of one transaction on the result channel
    typedef struct {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [15:0] conf;
    } t_match_result;

    // Software copy of the match table, predicting each result
    class t_match_table_model;
        logic [15:0]   thr;
        shortint       vec [N_ENT][N_DIM];
        bit            written [N_ENT][N_DIM];
        bit            valid [N_ENT];
        int            elen [N_ENT];
        shortint       qvec [N_DIM];
        bit            qwritten [N_DIM];
        int            cnt;
        int            tgt;
        t_match_result pending_results[$];
        int            errors;
        int            seen [8];

        function new();
            thr = 16'd39322;
            cnt = 0;
            tgt = 0;
            errors = 0;
            foreach (valid[i]) valid[i] = 0;
            foreach (qwritten[k]) qwritten[k] = 0;
            foreach (written[i, k]) written[i][k] = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function int valid_count();
            int n;
            n = 0;
            foreach (valid[i]) if (valid[i]) n++;
            return n;
        endfunction

        function int pick_valid();
            int cand[$];
            foreach (valid[i]) if (valid[i]) cand = {cand, i};
            if (cand.size() == 0) return -1;
            return cand[$urandom_range(0, cand.size() - 1)];
        endfunction

        // A query end that would read an element never written must not be sent
        function bit query_unsafe(logic [1:0] c, bit l);
            int len;
            if (c != CMD_QUERY || !l) return 0;
            len = (cnt < N_DIM) ? cnt + 1 : N_DIM;
            for (int k = 0; k < len; k++)
                if (k != cnt && !qwritten[k]) return 1;
            for (int i = 0; i < N_ENT; i++) begin
                if (valid[i] && elen[i] == len)
                    for (int k = 0; k < len; k++)
                        if (!written[i][k]) return 1;
            end
            return 0;
        endfunction

        function void push(logic [2:0] st, logic [5:0] sl, logic [15:0] cf);
            t_match_result r;
            r.status = st;
            r.slot = sl;
            r.conf = cf;
            pending_results = {pending_results, r};
        endfunction

        // Nearest entry by cosine similarity, cross-multiplied
        function void search(int len);
            logic [191:0] d, na, nb, t2, lhs, rhs, bd, bna, bnb, mine, theirs, tt;
            longint       dot, sa, sb;
            bit           found;
            int           best;
            logic [15:0]  c;
            found = 0;
            best = 0;
            bd = 0;
            bna = 0;
            bnb = 0;
            t2 = 192'(thr) * 192'(thr);
            for (int i = 0; i < N_ENT; i++) begin
                if (!valid[i] || elen[i] != len) continue;
                dot = 0;
                sa = 0;
                sb = 0;
                for (int k = 0; k < len; k++) begin
                    dot += longint'(vec[i][k]) * longint'(qvec[k]);
                    sa += longint'(vec[i][k]) * longint'(vec[i][k]);
                    sb += longint'(qvec[k]) * longint'(qvec[k]);
                end
                if (dot <= 0) continue;
                d = 192'(dot);
                na = 192'(sa);
                nb = 192'(sb);
                lhs = (d * d) << 32;
                rhs = na * nb * t2;
                if (lhs <= rhs) continue;
                if (found) begin
                    mine = d * d * bna;
                    theirs = bd * bd * na;
                    if (mine <= theirs) continue;
                end
                found = 1;
                best = i;
                bd = d;
                bna = na;
                bnb = nb;
            end
            if (!found) begin
                push(STS_STRANGER, 6'd0, 16'd0);
                return;
            end
            lhs = (bd * bd) << 32;
            c = 0;
            for (int b = 15; b >= 0; b--) begin
                tt = 192'(c | (16'd1 << b));
                if (bna * bnb * tt * tt <= lhs) c = c | (16'd1 << b);
            end
            push(STS_RECOGNISED, 6'(best), c);
        endfunction

        // Note one accepted input transaction
        function void accept_item(logic [1:0] c, logic signed [15:0] v, bit l,
                                  logic [5:0] s);
            int  pos, len;
            bit  usable;
            pos = cnt;
            if (c == CMD_REMOVE) begin
                if (!valid[s]) push(STS_NOT_FOUND, 6'd0, 16'd0);
                else begin
                    valid[s] = 0;
                    push(STS_REMOVED, s, 16'd0);
                end
                return;
            end
            if (c == CMD_UNUSED) return;
            if (cnt < N_DIM) cnt++;
            if (c == CMD_ENROLL) begin
                if (pos == 0) begin
                    tgt = N_ENT;
                    for (int i = 0; i < N_ENT; i++)
                        if (!valid[i]) begin
                            tgt = i;
                            break;
                        end
                end
                usable = tgt < N_ENT && !valid[tgt];
                if (usable && pos < N_DIM) begin
                    vec[tgt][pos] = v;
                    written[tgt][pos] = 1;
                end
                if (!l) return;
                len = cnt;
                cnt = 0;
                if (!usable) push(STS_FULL, 6'd0, 16'd0);
                else begin
                    valid[tgt] = 1;
                    elen[tgt] = len;
                    push(STS_ENROLLED, 6'(tgt), 16'd0);
                end
                return;
            end
            if (pos < N_DIM) begin
                qvec[pos] = v;
                qwritten[pos] = 1;
            end
            if (!l) return;
            len = cnt;
            cnt = 0;
            search(len);
        endfunction

        // Compare one result transaction with the oldest expectation
        task check_result(logic [2:0] st, logic [5:0] sl, logic [15:0] cf);
            t_match_result e;
            seen[st]++;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result status %0d slot %0d", st, sl));
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
            if (sl !== e.slot)
                report($sformatf("slot %0d, want %0d", sl, e.slot));
            if (cf !== e.conf)
                report($sformatf("confidence %0d, want %0d", cf, e.conf));
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic [1:0]         i_cmd = CMD_UNUSED;
    logic signed [15:0] i_value = 0;
    logic               i_last = 0;
    logic [5:0]         i_slot = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic [2:0]         o_status;
    logic [5:0]         o_match_slot;
    logic [15:0]        o_confidence;
    logic               i_cfg_we = 0;
    logic [15:0]        i_cfg_data = 0;

    t_match_table_model table_model = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int n_items = 0;

    cosine_nearest_match_table_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_last       (i_last),
        .i_slot       (i_slot),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_match_slot (o_match_slot),
        .o_confidence (o_confidence),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            table_model.check_result(o_status, o_match_slot, o_confidence);
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // One input transaction; called at a falling edge, returns at one
    task automatic send(input logic [1:0] c, input logic signed [15:0] v,
                        input bit l, input logic [5:0] s);
        if (table_model.query_unsafe(c, l)) c = CMD_REMOVE;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid <= 1;
        i_cmd <= c;
        i_value <= v;
        i_last <= l;
        i_slot <= s;
        do @(posedge i_clk); while (!o_ready);
        table_model.accept_item(c, v, l, s);
        if (c != CMD_UNUSED) n_items++;
        @(negedge i_clk);
    endtask

    task automatic send_vec(input logic [1:0] c, input shortint v[], input int len);
        for (int k = 0; k < len; k++)
            send(c, v[k], k == len - 1, 6'($urandom));
    endtask

    function automatic shortint rand_elem();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return shortint'($urandom);
        endcase
    endfunction

    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 6);
        if (r < 97) return $urandom_range(7, 16);
        return $urandom_range(120, 132);
    endfunction

    // Wait until no result is owed and the block has settled
    task automatic drain();
        i_valid <= 0;
        while (table_model.pending_results.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] t);
        i_cfg_we <= 1;
        i_cfg_data <= t;
        table_model.thr = t;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_phase(input int target);
        shortint v[];
        int      len, r, s;
        target += n_items;
        while (n_items < target) begin
            r = $urandom_range(0, 99);
            if (table_model.valid_count() > 58 && r < 45 && $urandom_range(0, 3) != 0)
                r = 85;
            if (r < 45) begin
                len = rand_len();
                v = new[len];
                foreach (v[k]) v[k] = rand_elem();
                send_vec(CMD_ENROLL, v, len);
            end else if (r < 80) begin
                s = table_model.pick_valid();
                if (s >= 0 && $urandom_range(0, 9) < 7) begin
                    len = table_model.elen[s];
                    v = new[len];
                    foreach (v[k]) begin
                        v[k] = table_model.vec[s][k];
                        case ($urandom_range(0, 3))
                            0: ;
                            1: v[k] = -v[k];
                            default: v[k] = shortint'(int'(v[k])
                                       + $urandom_range(0, 600) - 300);
                        endcase
                    end
                end else begin
                    len = rand_len();
                    v = new[len];
                    foreach (v[k]) v[k] = rand_elem();
                end
                send_vec(CMD_QUERY, v, len);
            end else if (r < 92) begin
                s = table_model.pick_valid();
                if (s < 0 || $urandom_range(0, 9) < 3) s = $urandom_range(0, 63);
                send(CMD_REMOVE, rand_elem(), $urandom_range(0, 1), 6'(s));
            end else if (r < 96) begin
                send(CMD_UNUSED, rand_elem(), $urandom_range(0, 1), 6'($urandom));
            end else begin
                // broken streams: enroll and query elements mixed
                repeat ($urandom_range(1, 4))
                    send(2'($urandom_range(0, 1)), rand_elem(),
                         $urandom_range(0, 2) == 0, 6'($urandom));
            end
        end
    endtask

    initial begin
        shortint v[];
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty table, extremes, removes, zero vectors, unused command
        send(CMD_QUERY, 16'sd32767, 1, 0);
        send(CMD_ENROLL, 16'sd32767, 1, 0);
        send(CMD_ENROLL, -16'sd32768, 1, 0);
        send(CMD_QUERY, 16'sd32767, 1, 0);
        send(CMD_QUERY, -16'sd32768, 1, 0);
        send(CMD_REMOVE, 0, 0, 6'd1);
        send(CMD_REMOVE, 0, 1, 6'd1);
        send(CMD_REMOVE, 0, 0, 6'd63);
        send(CMD_UNUSED, -16'sd1, 1, 6'd63);
        send(CMD_ENROLL, 0, 1, 0);
        send(CMD_QUERY, 0, 1, 0);
        v = new[3];
        v = '{16'sd1000, -16'sd2000, 16'sd3000};
        send_vec(CMD_ENROLL, v, 3);
        send_vec(CMD_ENROLL, v, 3);
        send_vec(CMD_QUERY, v, 3);
        v = '{16'sd999, -16'sd2001, 16'sd3002};
        send_vec(CMD_QUERY, v, 3);
        send(CMD_QUERY, 16'sd5, 0, 0);
        send(CMD_ENROLL, 16'sd7, 1, 0);
        drain();

        // Phases: idling pattern and threshold vary, one long receiver hold-off
        write_threshold(16'd0);
        random_phase(ITEMS_PER_PHASE);
        drain();
        idle_pct = 49;
        write_threshold(16'd65535);
        random_phase(ITEMS_PER_PHASE);
        drain();
        idle_pct = 0;
        stall_pct = 49;
        write_threshold(16'(($urandom_range(0, 65535))));
        hold_cycles <= 600;
        random_phase(ITEMS_PER_PHASE);
        drain();
        idle_pct = 34;
        stall_pct = 34;
        write_threshold(16'd39322);
        random_phase(ITEMS_PER_PHASE);
        drain();

        $display("tb: %0d input items; enrolled %0d, recognised %0d, stranger %0d",
                 n_items, table_model.seen[STS_ENROLLED], table_model.seen[STS_RECOGNISED],
                 table_model.seen[STS_STRANGER]);
        $display("tb: removed %0d, not found %0d, table full %0d",
                 table_model.seen[STS_REMOVED], table_model.seen[STS_NOT_FOUND],
                 table_model.seen[STS_FULL]);
        if (table_model.errors == 0 && table_model.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
